[src/sqv_pkg.sv]
package sqv_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 20;
  localparam int unsigned SCALE_FRAC_DEF  = 12;

  localparam int unsigned WIDE_W = 40;
  localparam int unsigned TW_W   = 34;
  localparam int unsigned PROD_W = TW_W + 17;
  localparam int unsigned SUM_W  = PROD_W + 2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_TEX   = 4;

  localparam logic signed [15:0] ANGLE_MIN    = 16'sd7;
  localparam logic [14:0]        FULL_TURN    = 15'd23040;
  localparam logic [14:0]        QUARTER_1    = 15'd5760;
  localparam logic [14:0]        QUARTER_2    = 15'd11520;
  localparam logic [14:0]        QUARTER_3    = 15'd17280;
  localparam logic [12:0]        QUARTER_TURN = 13'd5760;
  localparam logic [18:0]        RAD_PER_UNIT = 19'd292818;
  localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;
  localparam logic [16:0]        Q15_ONE      = 17'd32768;

  localparam int unsigned SIN_ROUNDS = 4;
  localparam int unsigned SIN_LAT    = 2 + 3 * SIN_ROUNDS + 2;
  localparam int unsigned SIN_DIV [SIN_ROUNDS] = '{72, 42, 20, 6};
  localparam logic [31:0] SIN_RECIP [SIN_ROUNDS] = '{
    32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
    32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)
  };

  localparam logic [2:0] LAST_VTX = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_TL = 3'd0,
    CFG_TEX_TR = 3'd1,
    CFG_TEX_BL = 3'd2,
    CFG_TEX_BR = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  typedef struct packed {
    logic                     locked;
    logic                     flip_x;
    logic                     flip_y;
    logic signed [WIDE_W-1:0] origin_x;
    logic signed [WIDE_W-1:0] origin_y;
    logic signed [WIDE_W-1:0] shift_x;
    logic signed [WIDE_W-1:0] shift_y;
    logic [15:0]              quad_width;
    logic [15:0]              quad_height;
    logic [15:0]              zoom;
    logic [15:0]              turn_angle;
    logic [31:0]              tint;
  } in_t;

  typedef struct packed {
    logic                     rot;
    logic                     swap_x;
    logic                     swap_y;
    quad_e                    quad;
    logic signed [TW_W-1:0]   tw;
    logic signed [TW_W-1:0]   th;
    logic signed [WIDE_W-1:0] ox;
    logic signed [WIDE_W-1:0] oy;
    logic [3:0][WIDE_W-1:0]   bx;
    logic [3:0][WIDE_W-1:0]   by;
    logic [31:0]              tint;
  } ctx_t;

  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [31:0] v;
    logic [31:0] q;
    logic [30:0] a;
  } sin_st_t;

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic corner_e vertex_corner(input logic [2:0] k);
    corner_e c;
    case (k)
      3'd0:    c = CORNER_TL;
      3'd1:    c = CORNER_BL;
      3'd2:    c = CORNER_BR;
      3'd3:    c = CORNER_TL;
      3'd4:    c = CORNER_TR;
      default: c = CORNER_BR;
    endcase
    return c;
  endfunction

endpackage

[src/sprite_quad_vertex_gen.sv]
// channel  | dir | handshake           | payload
// s_axis   | in  | tvalid/tready       | tdata: one sprite
// m_axis   | out | tvalid/tready/tlast | tdata: one vertex, tlast on sixth
// cfg      | in  | valid/ready         | addr: register index, data: texture corner
//
// 23-stage pipeline (16 of them the sine unit), one sprite may enter per cycle unless stalled.
// Six output words per sprite; the single vertex output register holds a sprite
// until its sixth vertex is taken. Stall on m_axis freezes the whole pipeline
// once its last stage holds a sprite; nothing is dropped or repeated.
// Reset clears valid bits, the output counter and the texture registers.
module sprite_quad_vertex_gen #(
  parameter int unsigned COORD_WIDTH     = sqv_pkg::COORD_WIDTH_DEF,
  parameter int unsigned SCALE_FRAC_BITS = sqv_pkg::SCALE_FRAC_DEF,
  parameter int unsigned IN_W            = ((3 + 4 * COORD_WIDTH + 96 + 7) / 8) * 8,
  parameter int unsigned OUT_W           = ((2 * COORD_WIDTH + 64 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // locked, flip_x, flip_y, origin_x, origin_y, shift_x, shift_y,
  // quad_width, quad_height, zoom, turn_angle, tint
  input  logic [IN_W-1:0]               s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // vert_x, vert_y, vert_color, vert_u, vert_v
  output logic [OUT_W-1:0]              m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sqv_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned WW    = sqv_pkg::WIDE_W;
  localparam int unsigned OX_LO = 3;
  localparam int unsigned OY_LO = OX_LO + CW;
  localparam int unsigned SX_LO = OY_LO + CW;
  localparam int unsigned SY_LO = SX_LO + CW;
  localparam int unsigned W_LO  = SY_LO + CW;
  localparam int unsigned H_LO  = W_LO + 16;
  localparam int unsigned Z_LO  = H_LO + 16;
  localparam int unsigned A_LO  = Z_LO + 16;
  localparam int unsigned T_LO  = A_LO + 16;
  localparam int unsigned NSTG  = 3 + sqv_pkg::SIN_LAT + 4;

  logic [3:0][31:0] tex_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_q <= '0;
    end else if (cfg_valid_i) begin
      case (sqv_pkg::cfg_idx_e'(cfg_addr_i))
        sqv_pkg::CFG_TEX_TL: tex_q[sqv_pkg::CORNER_TL] <= cfg_data_i;
        sqv_pkg::CFG_TEX_TR: tex_q[sqv_pkg::CORNER_TR] <= cfg_data_i;
        sqv_pkg::CFG_TEX_BL: tex_q[sqv_pkg::CORNER_BL] <= cfg_data_i;
        sqv_pkg::CFG_TEX_BR: tex_q[sqv_pkg::CORNER_BR] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic            adv, take;
  logic [NSTG-1:0] vld_q;

  assign adv             = !vld_q[NSTG-1] || take;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid_i};
    end
  end

  sqv_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.locked      <= s_axis_tdata_i[0];
      in_q.flip_x      <= s_axis_tdata_i[1];
      in_q.flip_y      <= s_axis_tdata_i[2];
      in_q.origin_x    <= WW'($signed(s_axis_tdata_i[OX_LO +: CW]));
      in_q.origin_y    <= WW'($signed(s_axis_tdata_i[OY_LO +: CW]));
      in_q.shift_x     <= WW'($signed(s_axis_tdata_i[SX_LO +: CW]));
      in_q.shift_y     <= WW'($signed(s_axis_tdata_i[SY_LO +: CW]));
      in_q.quad_width  <= s_axis_tdata_i[W_LO +: 16];
      in_q.quad_height <= s_axis_tdata_i[H_LO +: 16];
      in_q.zoom        <= s_axis_tdata_i[Z_LO +: 16];
      in_q.turn_angle  <= s_axis_tdata_i[A_LO +: 16];
      in_q.tint        <= s_axis_tdata_i[T_LO +: 32];
    end
  end

  sqv_pkg::ctx_t ctx_f;
  logic [12:0]   t_f, tc_f;

  sqv_front #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (adv),
    .in_i  (in_q),
    .ctx_o (ctx_f),
    .t_o   (t_f),
    .tc_o  (tc_f)
  );

  logic [15:0] sa, sb;

  sqv_sin u_sin_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .t_i   (t_f),
    .sin_o (sa)
  );

  sqv_sin u_sin_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .t_i   (tc_f),
    .sin_o (sb)
  );

  sqv_pkg::ctx_t dly_q [sqv_pkg::SIN_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0] <= ctx_f;
      for (int i = 1; i < sqv_pkg::SIN_LAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  logic [3:0][CW-1:0] cx, cy;
  logic [1:0]         swap;
  logic [31:0]        tint;

  sqv_geom #(
    .COORD_WIDTH    (COORD_WIDTH),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_geom (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ctx_i  (dly_q[sqv_pkg::SIN_LAT-1]),
    .sa_i   (sa),
    .sb_i   (sb),
    .cx_o   (cx),
    .cy_o   (cy),
    .swap_o (swap),
    .tint_o (tint)
  );

  sqv_emit #(
    .COORD_WIDTH(COORD_WIDTH),
    .OUT_W      (OUT_W)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (vld_q[NSTG-1]),
    .take_o          (take),
    .cx_i            (cx),
    .cy_i            (cy),
    .swap_i          (swap),
    .tint_i          (tint),
    .tex_i           (tex_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[src/sqv_sin.sv]
module sqv_sin (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [12:0] t_i,
  output logic [15:0] sin_o
);

  sqv_pkg::sin_st_t st_q [sqv_pkg::SIN_LAT];

  for (genvar j = 0; j < sqv_pkg::SIN_LAT; j++) begin : g_stg
    sqv_pkg::sin_st_t nxt;

    if (j == 0) begin : g_angle
      always_comb begin
        nxt   = '0;
        nxt.x = 31'(32'(t_i) * 32'(sqv_pkg::RAD_PER_UNIT));
      end
    end else if (j == 1) begin : g_square
      logic [61:0] prod;
      always_comb begin
        prod   = 62'(st_q[j-1].x) * 62'(st_q[j-1].x);
        nxt    = st_q[j-1];
        nxt.x2 = prod[61:30];
        nxt.a  = sqv_pkg::ONE_Q30;
      end
    end else if (j < sqv_pkg::SIN_LAT - 2) begin : g_round
      localparam int unsigned K  = (j - 2) / 3;
      localparam int unsigned PH = (j - 2) % 3;
      if (PH == 0) begin : g_mul
        logic [62:0] prod;
        always_comb begin
          prod  = 63'(st_q[j-1].x2) * 63'(st_q[j-1].a);
          nxt   = st_q[j-1];
          nxt.v = prod[61:30];
        end
      end else if (PH == 1) begin : g_recip
        logic [63:0] prod;
        always_comb begin
          prod  = 64'(st_q[j-1].v) * 64'(sqv_pkg::SIN_RECIP[K]);
          nxt   = st_q[j-1];
          nxt.q = prod[63:32];
        end
      end else begin : g_fix
        logic [33:0] rem;
        logic [31:0] qc;
        always_comb begin
          rem   = 34'(st_q[j-1].v) - 34'(st_q[j-1].q) * 34'(sqv_pkg::SIN_DIV[K]);
          qc    = st_q[j-1].q + 32'(rem >= 34'(sqv_pkg::SIN_DIV[K]));
          nxt   = st_q[j-1];
          nxt.a = sqv_pkg::ONE_Q30 - qc[30:0];
        end
      end
    end else if (j == sqv_pkg::SIN_LAT - 2) begin : g_final
      logic [61:0] prod;
      always_comb begin
        prod  = 62'(st_q[j-1].x) * 62'(st_q[j-1].a);
        nxt   = st_q[j-1];
        nxt.v = prod[61:30];
      end
    end else begin : g_out
      logic [16:0] rnd;
      always_comb begin
        rnd   = 17'((33'(st_q[j-1].v) + 33'd16384) >> 15);
        nxt   = st_q[j-1];
        nxt.q = (rnd > sqv_pkg::Q15_ONE) ? 32'(sqv_pkg::Q15_ONE) : 32'(rnd);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= nxt;
      end
    end
  end

  assign sin_o = st_q[sqv_pkg::SIN_LAT-1].q[15:0];

endmodule

[src/sqv_front.sv]
module sqv_front #(
  parameter int unsigned SCALE_FRAC_BITS = sqv_pkg::SCALE_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  sqv_pkg::in_t      in_i,
  output sqv_pkg::ctx_t     ctx_o,
  output logic [12:0]       t_o,
  output logic [12:0]       tc_o
);

  localparam int unsigned WW = sqv_pkg::WIDE_W;

  logic [31:0]                    tw_m, th_m;
  logic                           sx_e, sy_e;
  logic signed [sqv_pkg::TW_W-1:0] tw_d, th_d, tw_q, th_q;
  logic                           rot_d, rot_q, lk_q, sx_q, sy_q;
  logic [14:0]                    r_d, r_q;
  logic signed [WW-1:0]           mx, my, wx, hy;
  logic signed [WW-1:0]           el_d, er_d, et_d, eb_d, el_q, er_q, et_q, eb_q;
  logic signed [WW-1:0]           ox_q, oy_q;
  logic [31:0]                    tint_q;

  always_comb begin
    tw_m  = 32'(in_i.quad_width) * 32'(in_i.zoom);
    th_m  = 32'(in_i.quad_height) * 32'(in_i.zoom);
    sx_e  = in_i.flip_x & ~in_i.locked;
    sy_e  = in_i.flip_y & ~in_i.locked;
    tw_d  = sx_e ? -$signed({2'b00, tw_m}) : $signed({2'b00, tw_m});
    th_d  = sy_e ? -$signed({2'b00, th_m}) : $signed({2'b00, th_m});
    rot_d = ~in_i.locked && ($signed(in_i.turn_angle) >= sqv_pkg::ANGLE_MIN);
    r_d   = (in_i.turn_angle[14:0] >= sqv_pkg::FULL_TURN) ?
            in_i.turn_angle[14:0] - sqv_pkg::FULL_TURN : in_i.turn_angle[14:0];
    mx    = (in_i.origin_x + in_i.shift_x) <<< 1;
    my    = (in_i.origin_y + in_i.shift_y) <<< 1;
    wx    = $signed({{(WW-16){1'b0}}, in_i.quad_width});
    hy    = $signed({{(WW-16){1'b0}}, in_i.quad_height});
    el_d  = WW'(sqv_pkg::rnd_shift(64'(mx - wx), 5) <<< 4);
    er_d  = WW'(sqv_pkg::rnd_shift(64'(mx + wx), 5) <<< 4);
    et_d  = WW'(sqv_pkg::rnd_shift(64'(my - hy), 5) <<< 4);
    eb_d  = WW'(sqv_pkg::rnd_shift(64'(my + hy), 5) <<< 4);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tw_q   <= tw_d;
      th_q   <= th_d;
      rot_q  <= rot_d;
      r_q    <= r_d;
      lk_q   <= in_i.locked;
      sx_q   <= sx_e;
      sy_q   <= sy_e;
      ox_q   <= in_i.origin_x;
      oy_q   <= in_i.origin_y;
      tint_q <= in_i.tint;
      el_q   <= el_d;
      er_q   <= er_d;
      et_q   <= et_d;
      eb_q   <= eb_d;
    end
  end

  sqv_pkg::quad_e       quad;
  logic [14:0]          t_w;
  logic [12:0]          t_d;
  logic signed [WW-1:0] dx, dy;
  sqv_pkg::ctx_t        ctx_d;

  always_comb begin
    if (r_q >= sqv_pkg::QUARTER_3) begin
      quad = sqv_pkg::QUAD_IV;
      t_w  = r_q - sqv_pkg::QUARTER_3;
    end else if (r_q >= sqv_pkg::QUARTER_2) begin
      quad = sqv_pkg::QUAD_III;
      t_w  = r_q - sqv_pkg::QUARTER_2;
    end else if (r_q >= sqv_pkg::QUARTER_1) begin
      quad = sqv_pkg::QUAD_II;
      t_w  = r_q - sqv_pkg::QUARTER_1;
    end else begin
      quad = sqv_pkg::QUAD_I;
      t_w  = r_q;
    end
    t_d = t_w[12:0];
    dx  = WW'(sqv_pkg::rnd_shift(64'(tw_q), SCALE_FRAC_BITS));
    dy  = WW'(sqv_pkg::rnd_shift(64'(th_q), SCALE_FRAC_BITS));

    ctx_d        = '0;
    ctx_d.rot    = rot_q;
    ctx_d.swap_x = sx_q;
    ctx_d.swap_y = sy_q;
    ctx_d.quad   = quad;
    ctx_d.tw     = tw_q;
    ctx_d.th     = th_q;
    ctx_d.ox     = ox_q;
    ctx_d.oy     = oy_q;
    ctx_d.tint   = tint_q;
    if (lk_q) begin
      ctx_d.bx = {er_q, el_q, er_q, el_q};
      ctx_d.by = {eb_q, eb_q, et_q, et_q};
    end else begin
      ctx_d.bx = {ox_q + dx, ox_q, ox_q + dx, ox_q};
      ctx_d.by = {oy_q + dy, oy_q + dy, oy_q, oy_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_o <= ctx_d;
      t_o   <= t_d;
      tc_o  <= sqv_pkg::QUARTER_TURN - t_d;
    end
  end

endmodule

[src/sqv_geom.sv]
module sqv_geom #(
  parameter int unsigned COORD_WIDTH     = sqv_pkg::COORD_WIDTH_DEF,
  parameter int unsigned SCALE_FRAC_BITS = sqv_pkg::SCALE_FRAC_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  sqv_pkg::ctx_t               ctx_i,
  input  logic [15:0]                 sa_i,
  input  logic [15:0]                 sb_i,
  output logic [3:0][COORD_WIDTH-1:0] cx_o,
  output logic [3:0][COORD_WIDTH-1:0] cy_o,
  output logic [1:0]                  swap_o,
  output logic [31:0]                 tint_o
);

  localparam int unsigned WW = sqv_pkg::WIDE_W;
  localparam int unsigned PW = sqv_pkg::PROD_W;
  localparam int unsigned SW = sqv_pkg::SUM_W;
  localparam logic signed [WW-1:0] SAT_HI = WW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);

  // stage 1: sine/cosine by quadrant, products
  logic signed [16:0]   sa, sb, sn, cs;
  sqv_pkg::ctx_t        c1_q, c2_q, c3_q;
  logic signed [PW-1:0] p_twc_q, p_ths_q, p_tws_q, p_thc_q;

  always_comb begin
    sa = $signed({1'b0, sa_i});
    sb = $signed({1'b0, sb_i});
    case (ctx_i.quad)
      sqv_pkg::QUAD_I:   begin sn = sa;  cs = sb;  end
      sqv_pkg::QUAD_II:  begin sn = sb;  cs = -sa; end
      sqv_pkg::QUAD_III: begin sn = -sa; cs = -sb; end
      default:           begin sn = -sb; cs = sa;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q    <= ctx_i;
      p_twc_q <= PW'(ctx_i.tw) * PW'(cs);
      p_ths_q <= PW'(ctx_i.th) * PW'(sn);
      p_tws_q <= PW'(ctx_i.tw) * PW'(sn);
      p_thc_q <= PW'(ctx_i.th) * PW'(cs);
    end
  end

  // stage 2: corner sums
  logic signed [SW-1:0] twq, thq, a1, a2, b1, b2;
  logic signed [SW-1:0] nx_d [4], ny_d [4], nx_q [4], ny_q [4];

  always_comb begin
    twq = SW'(c1_q.tw) <<< 15;
    thq = SW'(c1_q.th) <<< 15;
    a1  = SW'(p_twc_q);
    a2  = SW'(p_ths_q);
    b1  = SW'(p_tws_q);
    b2  = SW'(p_thc_q);
    nx_d[0] = twq - a1 + a2;
    nx_d[1] = twq + a1 + a2;
    nx_d[2] = twq - a1 - a2;
    nx_d[3] = twq + a1 - a2;
    ny_d[0] = thq - b1 - b2;
    ny_d[1] = thq + b1 - b2;
    ny_d[2] = thq - b1 + b2;
    ny_d[3] = thq + b1 + b2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_q <= c1_q;
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
  end

  // stage 3: round to Q.4
  logic signed [WW-1:0] rx_q [4], ry_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q <= c2_q;
      for (int i = 0; i < 4; i++) begin
        rx_q[i] <= WW'(sqv_pkg::rnd_shift(64'(nx_q[i]), SCALE_FRAC_BITS + 16));
        ry_q[i] <= WW'(sqv_pkg::rnd_shift(64'(ny_q[i]), SCALE_FRAC_BITS + 16));
      end
    end
  end

  // stage 4: select mode, add origin, saturate
  logic signed [WW-1:0]        vx, vy;
  logic [3:0][COORD_WIDTH-1:0] cx_d, cy_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vx = c3_q.rot ? c3_q.ox + rx_q[i] : $signed(c3_q.bx[i]);
      vy = c3_q.rot ? c3_q.oy + ry_q[i] : $signed(c3_q.by[i]);
      vx = (vx > SAT_HI) ? SAT_HI : ((vx < SAT_LO) ? SAT_LO : vx);
      vy = (vy > SAT_HI) ? SAT_HI : ((vy < SAT_LO) ? SAT_LO : vy);
      cx_d[i] = vx[COORD_WIDTH-1:0];
      cy_d[i] = vy[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_o   <= cx_d;
      cy_o   <= cy_d;
      swap_o <= {c3_q.swap_y, c3_q.swap_x};
      tint_o <= c3_q.tint;
    end
  end

endmodule

[src/sqv_emit.sv]
module sqv_emit #(
  parameter int unsigned COORD_WIDTH = sqv_pkg::COORD_WIDTH_DEF,
  parameter int unsigned OUT_W       = ((2 * COORD_WIDTH + 64 + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        take_o,
  input  logic [3:0][COORD_WIDTH-1:0] cx_i,
  input  logic [3:0][COORD_WIDTH-1:0] cy_i,
  input  logic [1:0]                  swap_i,
  input  logic [31:0]                 tint_i,
  input  logic [3:0][31:0]            tex_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [OUT_W-1:0]            m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  logic                        busy_q;
  logic [2:0]                  k_q;
  logic [3:0][COORD_WIDTH-1:0] cx_q, cy_q;
  logic [1:0]                  swap_q;
  logic [31:0]                 tint_q;
  logic                        last;
  sqv_pkg::corner_e            c;
  logic [1:0]                  ti;

  assign last   = (k_q == sqv_pkg::LAST_VTX);
  assign take_o = valid_i && (!busy_q || (m_axis_tready_i && last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (take_o) begin
      busy_q <= 1'b1;
      k_q    <= '0;
    end else if (busy_q && m_axis_tready_i) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      cx_q   <= cx_i;
      cy_q   <= cy_i;
      swap_q <= swap_i;
      tint_q <= tint_i;
    end
  end

  always_comb begin
    c  = sqv_pkg::vertex_corner(k_q);
    ti = c ^ swap_q;
    m_axis_tdata_o = '0;
    m_axis_tdata_o[0 +: COORD_WIDTH]             = cx_q[c];
    m_axis_tdata_o[COORD_WIDTH +: COORD_WIDTH]   = cy_q[c];
    m_axis_tdata_o[2*COORD_WIDTH +: 32]          = tint_q;
    m_axis_tdata_o[2*COORD_WIDTH + 32 +: 16]     = tex_i[ti][31:16];
    m_axis_tdata_o[2*COORD_WIDTH + 48 +: 16]     = tex_i[ti][15:0];
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tlast_o  = last;

endmodule
